[sv/msl_pkg.sv]
// Shared types, codes and saturation helper for the mass-spring lattice step unit.
`timescale 1ns / 1ps
package msl_pkg;

    localparam int WORD_W     = 32;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;
    localparam int SQRT_STEPS = 32;
    localparam int CFG_IDX_W  = 3;

    typedef logic signed [WORD_W-1:0] word_t;

    localparam word_t SAT_MAX = 32'sh7fff_ffff;
    localparam word_t SAT_MIN = 32'sh8000_0000;

    typedef enum logic [1:0] {
        OP_LOAD       = 2'd0,
        OP_GRID_RESET = 2'd1,
        OP_STEP       = 2'd2,
        OP_READ       = 2'd3
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COUPLING = 3'd0,
        REG_REST     = 3'd1,
        REG_DT       = 3'd2,
        REG_INV_MASS = 3'd3,
        REG_START    = 3'd4,
        REG_SIZE_X   = 3'd5,
        REG_SIZE_Y   = 3'd6,
        REG_SIZE_Z   = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t vel_x;
        word_t vel_y;
        word_t vel_z;
    } granule_t;

    typedef struct packed {
        word_t fx;
        word_t fy;
        word_t fz;
    } force_t;

    function automatic word_t sat32(input logic signed [63:0] v);
        word_t r;
        if (v > 64'sd2147483647)
            r = SAT_MAX;
        else if (v < -64'sd2147483648)
            r = SAT_MIN;
        else
            r = v[WORD_W-1:0];
        return r;
    endfunction

endpackage

[sv/msl_mul.sv]
// Shared signed multiplier with registered product and fixed-point round/saturate.
`timescale 1ns / 1ps
module msl_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic signed [msl_pkg::MUL_W-1:0]   a,
    input  logic signed [msl_pkg::MUL_W-1:0]   b,
    output logic signed [msl_pkg::PROD_W-1:0]  prod,
    output msl_pkg::word_t                     rnd_f,
    output msl_pkg::word_t                     rnd_f1
);
    import msl_pkg::*;

    localparam logic signed [PROD_W:0] HALF_F  = (PROD_W+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W:0] HALF_F1 = (PROD_W+1)'(1) << FRAC_BITS;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W:0]   ext;
    logic signed [PROD_W:0]   sh_f;
    logic signed [PROD_W:0]   sh_f1;

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
    end

    // round to nearest, ties up, then clamp to 32 bits
    always_comb
    begin
        ext    = (PROD_W+1)'(prod_reg);
        sh_f   = (ext + HALF_F) >>> FRAC_BITS;
        sh_f1  = (ext + HALF_F1) >>> (FRAC_BITS + 1);
        rnd_f  = sat32(sh_f[63:0]);
        rnd_f1 = sat32(sh_f1[63:0]);
    end

    assign prod = prod_reg;

endmodule

[sv/msl_sqrt.sv]
// Bit-serial integer square root of a 64-bit value, one result bit per cycle.
`timescale 1ns / 1ps
module msl_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        go,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    import msl_pkg::*;

    localparam int CNT_W = $clog2(SQRT_STEPS);

    logic             run_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [63:0]      rad_reg;
    logic [34:0]      rem_reg;
    logic [31:0]      root_reg;
    logic [34:0]      rem_sh;
    logic [34:0]      trial;
    logic             fits;

    always_comb
    begin
        rem_sh = {rem_reg[32:0], rad_reg[63:62]};
        trial  = {1'b0, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= {rad_reg[61:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[sv/mass_spring_lattice_step_unit.sv]
// Top level: granule lattice stores, command sequencer and step datapath.
//
//  channel   signals                              direction  handshake
//  command   start/busy, opcode, cell_*, load_*   in         start && !busy
//  result    done, result_kind, out_*             out        done, one cycle
//  config    cfg_valid/cfg_ready, index, data     in         valid && ready
//
// A load is written from idle, a read passes through its read state and a grid reset
// writes every cell in use. A step walks the cells twice: first for forces, one spring
// term per present neighbor (one shared multiplier, a square root per spring), then
// for the update.
// After reset the force store is cleared one entry a cycle, all 2^(3*clog2(GRID_DIM))
// entries (4096 by default), with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
module mass_spring_lattice_step_unit #(
    parameter int GRID_DIM  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        opcode,
    input  logic [3:0]                        cell_x,
    input  logic [3:0]                        cell_y,
    input  logic [3:0]                        cell_z,
    input  msl_pkg::word_t                    load_pos_x,
    input  msl_pkg::word_t                    load_pos_y,
    input  msl_pkg::word_t                    load_pos_z,
    input  msl_pkg::word_t                    load_vel_x,
    input  msl_pkg::word_t                    load_vel_y,
    input  msl_pkg::word_t                    load_vel_z,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]                       cfg_data,
    output logic                              done,
    output logic                              result_kind,
    output msl_pkg::word_t                    out_pos_x,
    output msl_pkg::word_t                    out_pos_y,
    output msl_pkg::word_t                    out_pos_z,
    output msl_pkg::word_t                    out_vel_x,
    output msl_pkg::word_t                    out_vel_y,
    output msl_pkg::word_t                    out_vel_z,
    output msl_pkg::word_t                    out_force_x,
    output msl_pkg::word_t                    out_force_y,
    output msl_pkg::word_t                    out_force_z
);
    import msl_pkg::*;

    localparam int CW    = $clog2(GRID_DIM);
    localparam int SW    = CW + 1;
    localparam int AW    = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam int GW    = 31 + CW;
    localparam logic [2:0] NB_COUNT  = 3'd6;
    localparam logic [1:0] LAST_COMP = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_READ, S_ACK, S_GRST,
        FS_RD_SELF, FS_GET_SELF, FS_NB, FS_DIFF, FS_SQ_MUL, FS_SQ_ADD,
        FS_SQRT_GO, FS_SQRT_WAIT, FS_F_MUL, FS_F_GET, FS_T_MUL, FS_T_ADD, FS_WR,
        US_RD, US_GET, US_ACC_MUL, US_ACC_GET, US_V_MUL, US_V_GET, US_SUM,
        US_M_MUL, US_M_GET, US_WR
    } state_t;

    state_t state_reg;

    // configuration
    word_t        coupling_reg;
    logic [30:0]  rest_reg;
    logic [30:0]  dt_reg;
    logic [30:0]  inv_reg;
    logic [30:0]  startsp_reg;
    logic [4:0]   size_x_reg;
    logic [4:0]   size_y_reg;
    logic [4:0]   size_z_reg;

    // control
    logic [CW-1:0] ci_reg, cj_reg, ck_reg;
    logic [CW-1:0] ci_next, cj_next, ck_next;
    logic [2:0]    nb_reg;
    logic [1:0]    comp_reg;
    logic [AW-1:0] clr_reg;
    logic          done_reg;
    logic          kind_reg;

    // datapath
    word_t               self_reg [3];
    word_t               d_reg [3];
    logic [63:0]         sq_reg;
    word_t               diff_reg;
    word_t               f_reg;
    logic signed [35:0]  acc_reg [3];
    word_t               p_reg [3];
    word_t               v_reg [3];
    word_t               fr_reg [3];
    word_t               accel_reg;
    word_t               nv_reg;
    logic signed [32:0]  vsum_reg;
    logic [GW-1:0]       gx_reg, gy_reg, gz_reg;
    logic                rd_inside_reg;
    word_t               out_pos_reg [3];
    word_t               out_vel_reg [3];
    word_t               out_force_reg [3];

    // memories
    granule_t pv_mem [DEPTH];
    force_t   f_mem [DEPTH];
    granule_t pv_q;
    force_t   f_q;
    logic          pv_we;
    logic [AW-1:0] pv_waddr;
    granule_t      pv_wdata;
    logic          f_we;
    logic [AW-1:0] f_waddr;
    force_t        f_wdata;
    logic [AW-1:0] rd_addr;

    logic [SW-1:0] sx, sy, sz;
    logic          ci_last, cj_last, ck_last, cell_last, grid_empty;
    logic [AW-1:0] cell_addr, port_addr, nb_addr;
    logic          nb_exists;
    logic          port_inside;
    logic          accept;

    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_prod;
    word_t                    rnd_f, rnd_f1;
    logic                     sqrt_go, sqrt_done;
    logic [31:0]              sqrt_root;
    logic [30:0]              len31;

    function automatic word_t sat_grid(input logic [GW-1:0] g);
        word_t r;
        if (g > GW'(32'h7fff_ffff))
            r = SAT_MAX;
        else
            r = {1'b0, g[30:0]};
        return r;
    endfunction

    msl_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk    (clk),
        .a      (mul_a),
        .b      (mul_b),
        .prod   (mul_prod),
        .rnd_f  (rnd_f),
        .rnd_f1 (rnd_f1)
    );

    msl_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (sqrt_go),
        .radicand (sq_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    assign busy      = state_reg != S_IDLE;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign sqrt_go   = state_reg == FS_SQRT_GO;
    assign len31     = sqrt_root[31] ? 31'h7fff_ffff : sqrt_root[30:0];

    assign sx = (32'(size_x_reg) > 32'(GRID_DIM)) ? SW'(GRID_DIM) : SW'(size_x_reg);
    assign sy = (32'(size_y_reg) > 32'(GRID_DIM)) ? SW'(GRID_DIM) : SW'(size_y_reg);
    assign sz = (32'(size_z_reg) > 32'(GRID_DIM)) ? SW'(GRID_DIM) : SW'(size_z_reg);
    assign grid_empty = (sx == '0) || (sy == '0) || (sz == '0);

    assign ci_last   = (SW'(ci_reg) + SW'(1)) == sx;
    assign cj_last   = (SW'(cj_reg) + SW'(1)) == sy;
    assign ck_last   = (SW'(ck_reg) + SW'(1)) == sz;
    assign cell_last = ci_last && cj_last && ck_last;
    assign cell_addr = {ci_reg, cj_reg, ck_reg};

    assign port_inside = (32'(cell_x) < 32'(GRID_DIM)) && (32'(cell_y) < 32'(GRID_DIM))
                         && (32'(cell_z) < 32'(GRID_DIM));
    assign port_addr   = {CW'(cell_x), CW'(cell_y), CW'(cell_z)};

    always_comb
    begin
        ci_next = ci_reg;
        cj_next = cj_reg;
        ck_next = ck_reg + CW'(1);
        if (ck_last)
        begin
            ck_next = '0;
            cj_next = cj_reg + CW'(1);
            if (cj_last)
            begin
                cj_next = '0;
                ci_next = ci_reg + CW'(1);
            end
        end
    end

    // neighbor order: +x, +y, +z, -x, -y, -z
    always_comb
    begin
        nb_exists = 1'b0;
        nb_addr   = cell_addr;
        case (nb_reg)
            3'd0:
            begin
                nb_exists = !ci_last;
                nb_addr   = {ci_reg + CW'(1), cj_reg, ck_reg};
            end
            3'd1:
            begin
                nb_exists = !cj_last;
                nb_addr   = {ci_reg, cj_reg + CW'(1), ck_reg};
            end
            3'd2:
            begin
                nb_exists = !ck_last;
                nb_addr   = {ci_reg, cj_reg, ck_reg + CW'(1)};
            end
            3'd3:
            begin
                nb_exists = ci_reg != '0;
                nb_addr   = {ci_reg - CW'(1), cj_reg, ck_reg};
            end
            3'd4:
            begin
                nb_exists = cj_reg != '0;
                nb_addr   = {ci_reg, cj_reg - CW'(1), ck_reg};
            end
            3'd5:
            begin
                nb_exists = ck_reg != '0;
                nb_addr   = {ci_reg, cj_reg, ck_reg - CW'(1)};
            end
            default:
            begin
                nb_exists = 1'b0;
                nb_addr   = cell_addr;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_IDLE:  rd_addr = port_addr;
            FS_NB:   rd_addr = nb_addr;
            default: rd_addr = cell_addr;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            FS_SQ_MUL:
            begin
                mul_a = MUL_W'(d_reg[comp_reg]);
                mul_b = MUL_W'(d_reg[comp_reg]);
            end
            FS_F_MUL:
            begin
                mul_a = MUL_W'(coupling_reg);
                mul_b = MUL_W'(diff_reg);
            end
            FS_T_MUL:
            begin
                mul_a = MUL_W'(f_reg);
                mul_b = MUL_W'(d_reg[comp_reg]);
            end
            US_ACC_MUL:
            begin
                mul_a = MUL_W'(fr_reg[comp_reg]);
                mul_b = {2'b00, inv_reg};
            end
            US_V_MUL:
            begin
                mul_a = MUL_W'(accel_reg);
                mul_b = {2'b00, dt_reg};
            end
            US_M_MUL:
            begin
                mul_a = vsum_reg;
                mul_b = {2'b00, dt_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // store write ports; each cell is read, worked and written before the next read
    always_comb
    begin
        pv_we    = 1'b0;
        pv_waddr = cell_addr;
        pv_wdata = '0;
        f_we     = 1'b0;
        f_waddr  = cell_addr;
        f_wdata  = '0;
        case (state_reg)
            S_CLEAR:
            begin
                f_we    = 1'b1;
                f_waddr = clr_reg;
            end
            S_IDLE:
            begin
                if (accept && (opcode == OP_LOAD) && port_inside)
                begin
                    pv_we    = 1'b1;
                    pv_waddr = port_addr;
                    pv_wdata = '{pos_x: load_pos_x, pos_y: load_pos_y, pos_z: load_pos_z,
                                 vel_x: load_vel_x, vel_y: load_vel_y, vel_z: load_vel_z};
                end
            end
            S_GRST:
            begin
                pv_we          = 1'b1;
                pv_wdata.pos_x = sat_grid(gx_reg);
                pv_wdata.pos_y = sat_grid(gy_reg);
                pv_wdata.pos_z = sat_grid(gz_reg);
                f_we           = 1'b1;
            end
            FS_WR:
            begin
                f_we       = 1'b1;
                f_wdata.fx = sat32(64'(acc_reg[0]));
                f_wdata.fy = sat32(64'(acc_reg[1]));
                f_wdata.fz = sat32(64'(acc_reg[2]));
            end
            US_WR:
            begin
                pv_we    = 1'b1;
                pv_wdata = '{pos_x: p_reg[0], pos_y: p_reg[1], pos_z: p_reg[2],
                             vel_x: v_reg[0], vel_y: v_reg[1], vel_z: v_reg[2]};
            end
            default:
            begin
                pv_we = 1'b0;
                f_we  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pv_we)
            pv_mem[pv_waddr] <= pv_wdata;
        pv_q <= pv_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (f_we)
            f_mem[f_waddr] <= f_wdata;
        f_q <= f_mem[rd_addr];
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coupling_reg <= 32'sd65536;
            rest_reg     <= 31'd65536;
            dt_reg       <= 31'd655;
            inv_reg      <= 31'd65536;
            startsp_reg  <= 31'd65536;
            size_x_reg   <= 5'd4;
            size_y_reg   <= 5'd4;
            size_z_reg   <= 5'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COUPLING: coupling_reg <= cfg_data;
                REG_REST:     rest_reg     <= cfg_data[30:0];
                REG_DT:       dt_reg       <= cfg_data[30:0];
                REG_INV_MASS: inv_reg      <= cfg_data[30:0];
                REG_START:    startsp_reg  <= cfg_data[30:0];
                REG_SIZE_X:   size_x_reg   <= cfg_data[4:0];
                REG_SIZE_Y:   size_y_reg   <= cfg_data[4:0];
                REG_SIZE_Z:   size_z_reg   <= cfg_data[4:0];
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ci_reg    <= '0;
            cj_reg    <= '0;
            ck_reg    <= '0;
            nb_reg    <= '0;
            comp_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
            kind_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + AW'(1);
                    if (&clr_reg)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        ci_reg <= '0;
                        cj_reg <= '0;
                        ck_reg <= '0;
                        unique case (opcode_t'(opcode))
                            OP_LOAD:
                            begin
                                done_reg <= 1'b1;
                                kind_reg <= 1'b0;
                            end
                            OP_GRID_RESET:
                                state_reg <= grid_empty ? S_ACK : S_GRST;
                            OP_STEP:
                                state_reg <= grid_empty ? S_ACK : FS_RD_SELF;
                            OP_READ:
                                state_reg <= S_READ;
                        endcase
                    end
                end
                S_READ:
                begin
                    done_reg  <= 1'b1;
                    kind_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ACK:
                begin
                    done_reg  <= 1'b1;
                    kind_reg  <= 1'b0;
                    state_reg <= S_IDLE;
                end
                S_GRST:
                begin
                    ci_reg <= ci_next;
                    cj_reg <= cj_next;
                    ck_reg <= ck_next;
                    if (cell_last)
                        state_reg <= S_ACK;
                end
                FS_RD_SELF:
                    state_reg <= FS_GET_SELF;
                FS_GET_SELF:
                begin
                    nb_reg    <= '0;
                    state_reg <= FS_NB;
                end
                FS_NB:
                begin
                    if (nb_reg == NB_COUNT)
                        state_reg <= FS_WR;
                    else if (nb_exists)
                        state_reg <= FS_DIFF;
                    else
                        nb_reg <= nb_reg + 3'd1;
                end
                FS_DIFF:
                begin
                    comp_reg  <= '0;
                    state_reg <= FS_SQ_MUL;
                end
                FS_SQ_MUL:
                    state_reg <= FS_SQ_ADD;
                FS_SQ_ADD:
                begin
                    if (comp_reg == LAST_COMP)
                    begin
                        comp_reg  <= '0;
                        state_reg <= FS_SQRT_GO;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= FS_SQ_MUL;
                    end
                end
                FS_SQRT_GO:
                    state_reg <= FS_SQRT_WAIT;
                FS_SQRT_WAIT:
                begin
                    if (sqrt_done)
                        state_reg <= FS_F_MUL;
                end
                FS_F_MUL:
                    state_reg <= FS_F_GET;
                FS_F_GET:
                begin
                    comp_reg  <= '0;
                    state_reg <= FS_T_MUL;
                end
                FS_T_MUL:
                    state_reg <= FS_T_ADD;
                FS_T_ADD:
                begin
                    if (comp_reg == LAST_COMP)
                    begin
                        comp_reg  <= '0;
                        nb_reg    <= nb_reg + 3'd1;
                        state_reg <= FS_NB;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= FS_T_MUL;
                    end
                end
                FS_WR:
                begin
                    if (cell_last)
                    begin
                        ci_reg    <= '0;
                        cj_reg    <= '0;
                        ck_reg    <= '0;
                        state_reg <= US_RD;
                    end
                    else
                    begin
                        ci_reg    <= ci_next;
                        cj_reg    <= cj_next;
                        ck_reg    <= ck_next;
                        state_reg <= FS_RD_SELF;
                    end
                end
                US_RD:
                    state_reg <= US_GET;
                US_GET:
                begin
                    comp_reg  <= '0;
                    state_reg <= US_ACC_MUL;
                end
                US_ACC_MUL:
                    state_reg <= US_ACC_GET;
                US_ACC_GET:
                    state_reg <= US_V_MUL;
                US_V_MUL:
                    state_reg <= US_V_GET;
                US_V_GET:
                    state_reg <= US_SUM;
                US_SUM:
                    state_reg <= US_M_MUL;
                US_M_MUL:
                    state_reg <= US_M_GET;
                US_M_GET:
                begin
                    if (comp_reg == LAST_COMP)
                    begin
                        comp_reg  <= '0;
                        state_reg <= US_WR;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= US_ACC_MUL;
                    end
                end
                US_WR:
                begin
                    ci_reg <= ci_next;
                    cj_reg <= cj_next;
                    ck_reg <= ck_next;
                    state_reg <= cell_last ? S_ACK : US_RD;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                rd_inside_reg <= port_inside;
                gx_reg        <= '0;
                gy_reg        <= '0;
                gz_reg        <= '0;
                if (accept && (opcode == OP_LOAD))
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        out_pos_reg[c]   <= '0;
                        out_vel_reg[c]   <= '0;
                        out_force_reg[c] <= '0;
                    end
                end
            end
            S_READ:
            begin
                if (rd_inside_reg)
                begin
                    out_pos_reg[0]   <= pv_q.pos_x;
                    out_pos_reg[1]   <= pv_q.pos_y;
                    out_pos_reg[2]   <= pv_q.pos_z;
                    out_vel_reg[0]   <= pv_q.vel_x;
                    out_vel_reg[1]   <= pv_q.vel_y;
                    out_vel_reg[2]   <= pv_q.vel_z;
                    out_force_reg[0] <= f_q.fx;
                    out_force_reg[1] <= f_q.fy;
                    out_force_reg[2] <= f_q.fz;
                end
                else
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        out_pos_reg[c]   <= '0;
                        out_vel_reg[c]   <= '0;
                        out_force_reg[c] <= '0;
                    end
                end
            end
            S_ACK:
            begin
                for (int c = 0; c < 3; c++)
                begin
                    out_pos_reg[c]   <= '0;
                    out_vel_reg[c]   <= '0;
                    out_force_reg[c] <= '0;
                end
            end
            S_GRST:
            begin
                // running products start_spacing * coordinate
                if (ck_last)
                begin
                    gz_reg <= '0;
                    if (cj_last)
                    begin
                        gy_reg <= '0;
                        gx_reg <= gx_reg + GW'(startsp_reg);
                    end
                    else
                        gy_reg <= gy_reg + GW'(startsp_reg);
                end
                else
                    gz_reg <= gz_reg + GW'(startsp_reg);
            end
            FS_GET_SELF:
            begin
                self_reg[0] <= pv_q.pos_x;
                self_reg[1] <= pv_q.pos_y;
                self_reg[2] <= pv_q.pos_z;
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= '0;
            end
            FS_DIFF:
            begin
                d_reg[0] <= sat32(64'(pv_q.pos_x) - 64'(self_reg[0]));
                d_reg[1] <= sat32(64'(pv_q.pos_y) - 64'(self_reg[1]));
                d_reg[2] <= sat32(64'(pv_q.pos_z) - 64'(self_reg[2]));
                sq_reg   <= '0;
            end
            FS_SQ_ADD:
                sq_reg <= sq_reg + mul_prod[63:0];
            FS_SQRT_WAIT:
            begin
                if (sqrt_done)
                    diff_reg <= $signed({1'b0, len31}) - $signed({1'b0, rest_reg});
            end
            FS_F_GET:
                f_reg <= rnd_f;
            FS_T_ADD:
                acc_reg[comp_reg] <= acc_reg[comp_reg] + 36'(rnd_f);
            US_GET:
            begin
                p_reg[0]  <= pv_q.pos_x;
                p_reg[1]  <= pv_q.pos_y;
                p_reg[2]  <= pv_q.pos_z;
                v_reg[0]  <= pv_q.vel_x;
                v_reg[1]  <= pv_q.vel_y;
                v_reg[2]  <= pv_q.vel_z;
                fr_reg[0] <= f_q.fx;
                fr_reg[1] <= f_q.fy;
                fr_reg[2] <= f_q.fz;
            end
            US_ACC_GET:
                accel_reg <= rnd_f;
            US_V_GET:
                nv_reg <= sat32(64'(v_reg[comp_reg]) + 64'(rnd_f));
            US_SUM:
                vsum_reg <= 33'(v_reg[comp_reg]) + 33'(nv_reg);
            US_M_GET:
            begin
                p_reg[comp_reg] <= sat32(64'(p_reg[comp_reg]) + 64'(rnd_f1));
                v_reg[comp_reg] <= nv_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign out_pos_x   = out_pos_reg[0];
    assign out_pos_y   = out_pos_reg[1];
    assign out_pos_z   = out_pos_reg[2];
    assign out_vel_x   = out_vel_reg[0];
    assign out_vel_y   = out_vel_reg[1];
    assign out_vel_z   = out_vel_reg[2];
    assign out_force_x = out_force_reg[0];
    assign out_force_y = out_force_reg[1];
    assign out_force_z = out_force_reg[2];

    a_sqrt_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == FS_SQRT_WAIT)
        else $error("square root finished outside its wait state");

    a_read_word_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result_kind) |-> $past(state_reg == S_READ))
        else $error("read word without a read");

    a_diff_needs_neighbor: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_DIFF) |-> $past(nb_exists && (state_reg == FS_NB)))
        else $error("spring term on a missing neighbor");

    a_no_write_in_force_pass: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == FS_NB || state_reg == FS_DIFF || state_reg == FS_T_ADD) |-> !pv_we)
        else $error("position store written during force pass");

endmodule

[bench/mass_spring_lattice_step_unit_tb.sv]
// Self-checking bench for the lattice step unit: directed and random commands, config phases.
`timescale 1ns / 1ps
module mass_spring_lattice_step_unit_tb;
    import msl_pkg::*;

    localparam int DIM        = 16;
    localparam int CELL_COUNT = DIM * DIM * DIM;
    localparam int FRAC       = 16;
    localparam int IDLE_LIMIT = 200000;

    typedef struct {
        opcode_t    op;
        logic [3:0] x, y, z;
        word_t      px, py, pz, vx, vy, vz;
    } command_t;

    typedef struct {
        logic  kind;
        word_t px, py, pz, vx, vy, vz, fx, fy, fz;
    } granule_word_t;

    class lattice_scoreboard;
        word_t pos_x[CELL_COUNT], pos_y[CELL_COUNT], pos_z[CELL_COUNT];
        word_t vel_x[CELL_COUNT], vel_y[CELL_COUNT], vel_z[CELL_COUNT];
        word_t frc_x[CELL_COUNT], frc_y[CELL_COUNT], frc_z[CELL_COUNT];
        word_t coupling, rest_len, dt, inv_mass, spacing;
        logic [4:0] nx, ny, nz;
        granule_word_t pending_words[$];
        int errors;

        function new();
            coupling = 65536;
            rest_len = 65536;
            dt       = 655;
            inv_mass = 65536;
            spacing  = 65536;
            nx = 4;
            ny = 4;
            nz = 4;
            errors = 0;
            for (int i = 0; i < CELL_COUNT; i++)
            begin
                pos_x[i] = 0; pos_y[i] = 0; pos_z[i] = 0;
                vel_x[i] = 0; vel_y[i] = 0; vel_z[i] = 0;
                frc_x[i] = 0; frc_y[i] = 0; frc_z[i] = 0;
            end
        endfunction

        function int pending();
            return pending_words.size();
        endfunction

        function word_t clip(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fff_ffff;
            if (v < -64'sd2147483648)
                return 32'sh8000_0000;
            return word_t'(v);
        endfunction

        // round half up, arithmetic shift floors
        function longint round_shift(longint p, int sh);
            return (p + (64'sd1 <<< (sh - 1))) >>> sh;
        endfunction

        function word_t qmul(word_t a, word_t b);
            return clip(round_shift(longint'(a) * longint'(b), FRAC));
        endfunction

        function logic [63:0] root64(logic [63:0] n);
            logic [63:0] res, bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (n >= res + bitv)
                begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                    res = res >> 1;
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function int lim(logic [4:0] s);
            return (s > DIM) ? DIM : int'(s);
        endfunction

        function int at(int x, int y, int z);
            return (x * DIM + y) * DIM + z;
        endfunction

        function void add_link(int me, int nb, inout longint ax, inout longint ay,
                               inout longint az);
            word_t dx, dy, dz, f;
            logic [63:0] sq, len;
            dx = clip(longint'(pos_x[nb]) - longint'(pos_x[me]));
            dy = clip(longint'(pos_y[nb]) - longint'(pos_y[me]));
            dz = clip(longint'(pos_z[nb]) - longint'(pos_z[me]));
            sq = 64'(longint'(dx) * dx) + 64'(longint'(dy) * dy) + 64'(longint'(dz) * dz);
            len = root64(sq);
            if (len > 64'd2147483647)
                len = 64'd2147483647;
            f = qmul(coupling, clip(longint'(len) - longint'(rest_len)));
            ax += qmul(f, dx);
            ay += qmul(f, dy);
            az += qmul(f, dz);
        endfunction

        function void integrate(input word_t p, input word_t v, input word_t f,
                                output word_t np, output word_t nv);
            word_t acc;
            longint move;
            acc = qmul(f, inv_mass);
            nv = clip(longint'(v) + qmul(acc, dt));
            move = round_shift((longint'(v) + longint'(nv)) * longint'(dt), FRAC + 1);
            np = clip(longint'(p) + clip(move));
        endfunction

        function void run_step();
            int sx, sy, sz, n;
            longint ax, ay, az;
            sx = lim(nx); sy = lim(ny); sz = lim(nz);
            for (int i = 0; i < sx; i++)
                for (int j = 0; j < sy; j++)
                    for (int k = 0; k < sz; k++)
                    begin
                        n = at(i, j, k);
                        ax = 0; ay = 0; az = 0;
                        if (i + 1 < sx) add_link(n, at(i + 1, j, k), ax, ay, az);
                        if (j + 1 < sy) add_link(n, at(i, j + 1, k), ax, ay, az);
                        if (k + 1 < sz) add_link(n, at(i, j, k + 1), ax, ay, az);
                        if (i > 0) add_link(n, at(i - 1, j, k), ax, ay, az);
                        if (j > 0) add_link(n, at(i, j - 1, k), ax, ay, az);
                        if (k > 0) add_link(n, at(i, j, k - 1), ax, ay, az);
                        frc_x[n] = clip(ax);
                        frc_y[n] = clip(ay);
                        frc_z[n] = clip(az);
                    end
            for (int i = 0; i < sx; i++)
                for (int j = 0; j < sy; j++)
                    for (int k = 0; k < sz; k++)
                    begin
                        n = at(i, j, k);
                        integrate(pos_x[n], vel_x[n], frc_x[n], pos_x[n], vel_x[n]);
                        integrate(pos_y[n], vel_y[n], frc_y[n], pos_y[n], vel_y[n]);
                        integrate(pos_z[n], vel_z[n], frc_z[n], pos_z[n], vel_z[n]);
                    end
        endfunction

        function void lay_out_grid();
            int n;
            for (int i = 0; i < lim(nx); i++)
                for (int j = 0; j < lim(ny); j++)
                    for (int k = 0; k < lim(nz); k++)
                    begin
                        n = at(i, j, k);
                        pos_x[n] = clip(longint'(spacing) * i);
                        pos_y[n] = clip(longint'(spacing) * j);
                        pos_z[n] = clip(longint'(spacing) * k);
                        vel_x[n] = 0; vel_y[n] = 0; vel_z[n] = 0;
                        frc_x[n] = 0; frc_y[n] = 0; frc_z[n] = 0;
                    end
        endfunction

        function void write_reg(cfg_reg_t idx, logic [31:0] data);
            case (idx)
                REG_COUPLING: coupling = word_t'(data);
                REG_REST:     rest_len = word_t'({1'b0, data[30:0]});
                REG_DT:       dt       = word_t'({1'b0, data[30:0]});
                REG_INV_MASS: inv_mass = word_t'({1'b0, data[30:0]});
                REG_START:    spacing  = word_t'({1'b0, data[30:0]});
                REG_SIZE_X:   nx = data[4:0];
                REG_SIZE_Y:   ny = data[4:0];
                REG_SIZE_Z:   nz = data[4:0];
                default: ;
            endcase
        endfunction

        function void note_command(command_t c);
            granule_word_t w;
            int n;
            n = at(c.x, c.y, c.z);
            w = '{default: 0};
            case (c.op)
                OP_LOAD:
                begin
                    pos_x[n] = c.px; pos_y[n] = c.py; pos_z[n] = c.pz;
                    vel_x[n] = c.vx; vel_y[n] = c.vy; vel_z[n] = c.vz;
                end
                OP_GRID_RESET: lay_out_grid();
                OP_STEP: run_step();
                default:
                begin
                    w.kind = 1'b1;
                    w.px = pos_x[n]; w.py = pos_y[n]; w.pz = pos_z[n];
                    w.vx = vel_x[n]; w.vy = vel_y[n]; w.vz = vel_z[n];
                    w.fx = frc_x[n]; w.fy = frc_y[n]; w.fz = frc_z[n];
                end
            endcase
            pending_words.push_back(w);
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            $display("%0t MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        endtask

        task check_word(granule_word_t g);
            granule_word_t w;
            if (pending_words.size() == 0)
            begin
                report("unexpected result word", g.kind, -1);
                return;
            end
            w = pending_words.pop_front();
            if (g.kind !== w.kind) report("result_kind", g.kind, w.kind);
            if (g.px !== w.px) report("out_pos_x", g.px, w.px);
            if (g.py !== w.py) report("out_pos_y", g.py, w.py);
            if (g.pz !== w.pz) report("out_pos_z", g.pz, w.pz);
            if (g.vx !== w.vx) report("out_vel_x", g.vx, w.vx);
            if (g.vy !== w.vy) report("out_vel_y", g.vy, w.vy);
            if (g.vz !== w.vz) report("out_vel_z", g.vz, w.vz);
            if (g.fx !== w.fx) report("out_force_x", g.fx, w.fx);
            if (g.fy !== w.fy) report("out_force_y", g.fy, w.fy);
            if (g.fz !== w.fz) report("out_force_z", g.fz, w.fz);
        endtask
    endclass

    logic clk, rst_n, start, busy, cfg_valid, cfg_ready, done, result_kind;
    logic [1:0] opcode;
    logic [3:0] cell_x, cell_y, cell_z;
    word_t load_pos_x, load_pos_y, load_pos_z, load_vel_x, load_vel_y, load_vel_z;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0] cfg_data;
    word_t out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z;
    word_t out_force_x, out_force_y, out_force_z;

    mass_spring_lattice_step_unit dut (.*);

    lattice_scoreboard sb;
    int idle_cycles;
    bit written[CELL_COUNT];
    int written_list[$];
    int size_x, size_y, size_z;
    bit no_gaps;
    command_t cmd;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        command_t c;
        granule_word_t g;
        bit moved;
        moved = 0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
                moved = 1;
            end
            if (start && !busy)
            begin
                c.op = opcode_t'(opcode);
                c.x = cell_x; c.y = cell_y; c.z = cell_z;
                c.px = load_pos_x; c.py = load_pos_y; c.pz = load_pos_z;
                c.vx = load_vel_x; c.vy = load_vel_y; c.vz = load_vel_z;
                sb.note_command(c);
                moved = 1;
            end
            if (done)
            begin
                g.kind = result_kind;
                g.px = out_pos_x; g.py = out_pos_y; g.pz = out_pos_z;
                g.vx = out_vel_x; g.vy = out_vel_y; g.vz = out_vel_z;
                g.fx = out_force_x; g.fy = out_force_y; g.fz = out_force_z;
                sb.check_word(g);
                moved = 1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("mass_spring_lattice_step_unit_tb: done, errors");
            $finish;
        end
    end

    function int cell_at(int x, int y, int z);
        return (x * DIM + y) * DIM + z;
    endfunction

    function int eff(int s);
        return (s > DIM) ? DIM : s;
    endfunction

    function void mark(int n);
        if (!written[n])
        begin
            written[n] = 1;
            written_list.push_back(n);
        end
    endfunction

    function bit region_ready();
        for (int i = 0; i < eff(size_x); i++)
            for (int j = 0; j < eff(size_y); j++)
                for (int k = 0; k < eff(size_z); k++)
                    if (!written[cell_at(i, j, k)])
                        return 0;
        return 1;
    endfunction

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task send(command_t c);
        int gap;
        if (c.op == OP_LOAD)
            mark(cell_at(c.x, c.y, c.z));
        if (c.op == OP_GRID_RESET)
            for (int i = 0; i < eff(size_x); i++)
                for (int j = 0; j < eff(size_y); j++)
                    for (int k = 0; k < eff(size_z); k++)
                        mark(cell_at(i, j, k));
        start <= 1'b1;
        opcode <= c.op;
        cell_x <= c.x; cell_y <= c.y; cell_z <= c.z;
        load_pos_x <= c.px; load_pos_y <= c.py; load_pos_z <= c.pz;
        load_vel_x <= c.vx; load_vel_y <= c.vy; load_vel_z <= c.vz;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task write_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == REG_SIZE_X) size_x = int'(data[4:0]);
        if (idx == REG_SIZE_Y) size_y = int'(data[4:0]);
        if (idx == REG_SIZE_Z) size_z = int'(data[4:0]);
        // hold valid into the next word unless a gap follows
        if ($urandom_range(0, 3) == 0)
        begin
            cfg_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task set_all(logic [31:0] k, logic [31:0] r, logic [31:0] t, logic [31:0] m,
                 logic [31:0] s, int sx, int sy, int sz);
        drain();
        write_reg(REG_COUPLING, k);
        write_reg(REG_REST, r);
        write_reg(REG_DT, t);
        write_reg(REG_INV_MASS, m);
        write_reg(REG_START, s);
        write_reg(REG_SIZE_X, sx);
        write_reg(REG_SIZE_Y, sy);
        write_reg(REG_SIZE_Z, sz);
        cfg_valid <= 1'b0;
    endtask

    function command_t simple(opcode_t op, int x, int y, int z);
        command_t c;
        c.op = op;
        c.x = 4'(x); c.y = 4'(y); c.z = 4'(z);
        c.px = $urandom; c.py = $urandom; c.pz = $urandom;
        c.vx = $urandom; c.vy = $urandom; c.vz = $urandom;
        return c;
    endfunction

    function command_t random_command();
        command_t c;
        int r, n;
        r = $urandom_range(0, 99);
        c = simple(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                   $urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0 && eff(size_x) > 0 && eff(size_y) > 0
            && eff(size_z) > 0)
        begin
            c.x = 4'($urandom_range(0, eff(size_x) - 1));
            c.y = 4'($urandom_range(0, eff(size_y) - 1));
            c.z = 4'($urandom_range(0, eff(size_z) - 1));
        end
        if (r < 30)
        begin
            c.op = OP_LOAD;
            if ($urandom_range(0, 3) != 0)
            begin
                // stay near the rest lattice so the springs do real work
                c.px = 32'sd65536 * c.x + $signed($urandom_range(0, 131072)) - 65536;
                c.py = 32'sd65536 * c.y + $signed($urandom_range(0, 131072)) - 65536;
                c.pz = 32'sd65536 * c.z + $signed($urandom_range(0, 131072)) - 65536;
                c.vx = $signed($urandom_range(0, 32768)) - 16384;
                c.vy = $signed($urandom_range(0, 32768)) - 16384;
                c.vz = $signed($urandom_range(0, 32768)) - 16384;
            end
        end
        else if (r < 40)
            c.op = OP_GRID_RESET;
        else if (r < 65)
            c.op = region_ready() ? OP_STEP : OP_GRID_RESET;
        else
        begin
            n = cell_at(c.x, c.y, c.z);
            if (!written[n])
            begin
                n = written_list[$urandom_range(0, written_list.size() - 1)];
                c.x = 4'(n / (DIM * DIM));
                c.y = 4'((n / DIM) % DIM);
                c.z = 4'(n % DIM);
            end
        end
        return c;
    endfunction

    initial
    begin
        sb = new();
        idle_cycles = 0;
        size_x = 4; size_y = 4; size_z = 4;
        no_gaps = 0;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= OP_LOAD;
        cell_x <= '0; cell_y <= '0; cell_z <= '0;
        load_pos_x <= '0; load_pos_y <= '0; load_pos_z <= '0;
        load_vel_x <= '0; load_vel_y <= '0; load_vel_z <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_COUPLING;
        cfg_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default setup, lattice at rest, then extremes
        send(simple(OP_GRID_RESET, 0, 0, 0));
        send(simple(OP_READ, 0, 0, 0));
        send(simple(OP_STEP, 0, 0, 0));
        send(simple(OP_READ, 3, 3, 3));
        cmd = simple(OP_LOAD, 1, 2, 3);
        cmd.px = 32'sh7fff_ffff; cmd.py = 32'sh8000_0000; cmd.pz = 0;
        cmd.vx = 32'sh8000_0000; cmd.vy = 32'sh7fff_ffff; cmd.vz = -1;
        send(cmd);
        send(simple(OP_STEP, 0, 0, 0));
        send(simple(OP_READ, 1, 2, 3));
        send(simple(OP_READ, 0, 2, 3));
        // load and read outside the cells in use
        send(simple(OP_LOAD, 15, 15, 15));
        send(simple(OP_READ, 15, 15, 15));
        send(simple(OP_LOAD, 15, 0, 9));
        send(simple(OP_READ, 15, 0, 9));

        // sizes above the grid fold to the grid, one long axis
        set_all(32'h8000_0000, 32'hffff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 31, 1, 1);
        send(simple(OP_GRID_RESET, 0, 0, 0));
        send(simple(OP_STEP, 0, 0, 0));
        send(simple(OP_READ, 15, 0, 0));
        send(simple(OP_READ, 1, 0, 0));

        // empty grid: reset and step touch nothing
        set_all(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 32'h0, 0, 16, 16);
        send(simple(OP_GRID_RESET, 0, 0, 0));
        send(simple(OP_STEP, 0, 0, 0));
        send(simple(OP_READ, 15, 0, 0));
        send(simple(OP_READ, 1, 2, 3));

        for (int phase = 0; phase < 9; phase++)
        begin
            no_gaps = (phase % 3 == 1);
            if (phase % 4 == 3)
                set_all($urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
            else
                set_all($signed($urandom_range(0, 262144)) - 131072,
                        $urandom_range(0, 131072), $urandom_range(0, 65536),
                        $urandom_range(0, 262144), $urandom_range(32768, 98304),
                        $urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
            if ($urandom_range(0, 1))
                send(simple(OP_GRID_RESET, 0, 0, 0));
            repeat (12)
                send(random_command());
        end

        drain();
        if (sb.errors == 0)
            $display("mass_spring_lattice_step_unit_tb: done, clean");
        else
            $display("mass_spring_lattice_step_unit_tb: done, errors");
        $finish;
    end
endmodule
